FILE: rtl/core/mfbp_pkg.sv
package mfbp_pkg;

  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned VALUE_W    = 63;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [COUNT_W-1:0]   bit_count;
    logic [VALUE_W-1:0]   value_bits;
  } in_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last_byte;
  } out_t;

endpackage

FILE: rtl/core/mfbp_front.sv
module mfbp_front import mfbp_pkg::*; #(
  parameter int unsigned MAX_FIELD_BITS = 63
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic q_valid,
  input  logic q_take,
  output in_t  q_head
);

  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_FIELD_BITS);

  in_t        mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  in_t        cls;
  logic       accept;
  logic       keep;
  logic       deq;

  // saturate the count and drop appends that carry no bits
  always_comb begin
    cls = item;
    if (item.bit_count > MAX_CNT) begin
      cls.bit_count = MAX_CNT;
    end
    keep = (item.action == ACT_FLUSH) || (item.bit_count != '0);
  end

  assign full    = (count == 2'd2);
  assign accept  = push && !full;
  assign q_valid = (count != 2'd0);
  assign deq     = q_take && q_valid;
  assign q_head  = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (accept && keep && !deq) begin
      count_next = count + 2'd1;
    end else if (deq && !(accept && keep)) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (accept && keep) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      mem[wr_ptr] <= cls;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

  a_head_saturated: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_head.bit_count <= MAX_CNT))
    else $error("queued count above field limit");

  a_no_empty_append: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_head.action == ACT_APPEND) |-> (q_head.bit_count != '0))
    else $error("zero-length append reached the queue");

endmodule

FILE: rtl/core/mfbp_back.sv
module mfbp_back import mfbp_pkg::*; #(
  parameter int unsigned MAX_FIELD_BITS = 63
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_take,
  input  in_t  q_head,
  output logic empty,
  input  logic pop,
  output out_t result
);

  localparam int unsigned AW = MAX_FIELD_BITS + BYTE_BITS - 1;
  localparam int unsigned NW = $clog2(AW + 1);
  localparam logic [NW-1:0] BYTE_N = NW'(BYTE_BITS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [AW-1:0]        acc;
  logic [AW-1:0]        acc_next;
  logic [NW-1:0]        nbits;
  logic [NW-1:0]        nbits_next;
  logic [NW-1:0]        rem;
  logic                 out_valid;
  logic                 out_free;
  logic                 emit;
  out_t                 emit_data;
  logic [AW+VALUE_W-1:0] vwide;
  logic [AW-1:0]        vext;
  logic [AW-1:0]        vmask;
  logic [AW-1:0]        shifted;
  logic [BYTE_BITS-1:0] flush_byte;
  logic [2:0]           pad;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign rem      = nbits - BYTE_N;
  assign shifted  = acc >> rem;

  always_comb begin
    vwide = {{AW{1'b0}}, q_head.value_bits};
    vext  = vwide[AW-1:0];
    vmask = vext & ~({AW{1'b1}} << q_head.bit_count);
    pad   = 3'(4'd8 - {1'b0, nbits[2:0]});
    flush_byte = {1'b0, acc[BYTE_BITS-2:0]} << pad;
  end

  always_comb begin
    state_next = state;
    acc_next   = acc;
    nbits_next = nbits;
    q_take     = 1'b0;
    emit       = 1'b0;
    emit_data  = '0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_head.action == ACT_FLUSH) begin
            if (nbits == '0) begin
              q_take = 1'b1;
            end else if (out_free) begin
              q_take              = 1'b1;
              emit                = 1'b1;
              emit_data.out_byte  = flush_byte;
              emit_data.last_byte = 1'b1;
              nbits_next          = '0;
            end
          end else begin
            q_take     = 1'b1;
            acc_next   = (acc << q_head.bit_count) | vmask;
            nbits_next = nbits + NW'(q_head.bit_count);
            if (nbits_next >= BYTE_N) begin
              state_next = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_data.out_byte  = shifted[BYTE_BITS-1:0];
          emit_data.last_byte = (rem < BYTE_N);
          nbits_next          = rem;
          if (rem < BYTE_N) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      nbits     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      nbits <= nbits_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // bits above nbits are don't-care, so the accumulator needs no reset
  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (emit) begin
      result <= emit_data;
    end
  end

  a_idle_partial: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (nbits < BYTE_N))
    else $error("whole byte left pending while idle");

  a_emit_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (nbits >= BYTE_N))
    else $error("emitting without a whole byte");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(result)))
    else $error("waiting result lost or changed");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |-> (state == ST_IDLE && q_valid))
    else $error("queue read outside idle");

endmodule

FILE: rtl/core/msb_first_bit_packer_top.sv
// Channel  | Ports                   | Beat taken when
// -------- | ----------------------- | ------------------------
// item     | push, full, item        | push && !full
// result   | empty, pop, result      | pop && !empty
//
// An append loads into the accumulator, then each complete byte (up to eight)
// is emitted in turn; a flush emits any pending partial byte, zero-padded. The
// back end's byte loop sets the rate. A two-beat queue sits between intake and
// the byte loop. The one-beat result register refills only when empty or
// popped in the same cycle, so the loop stalls while a byte waits unpopped.
// Synchronous reset clears pending bits and empties queue and result register.
module msb_first_bit_packer_top import mfbp_pkg::*; #(
  parameter int unsigned MAX_FIELD_BITS = 63
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic empty,
  input  logic pop,
  output out_t result
);

  logic q_valid;
  logic q_take;
  in_t  q_head;

  mfbp_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_valid(q_valid),
    .q_take (q_take),
    .q_head (q_head)
  );

  mfbp_back #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_take (q_take),
    .q_head (q_head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import mfbp_pkg::*;

  localparam int unsigned FIELD_LIMIT = 63;
  localparam int unsigned RANDOM_ITEMS = 128;

  // Tracks the pending bits and the byte stream they must turn into.
  class packed_byte_tracker;
    out_t        expected_bytes[$];
    logic [6:0]  held_bits;
    int unsigned held_count;
    int unsigned errors;

    function new();
      held_bits = '0;
      held_count = 0;
      errors = 0;
    endfunction

    function void note_item(in_t it);
      out_t        b;
      logic [7:0]  acc;
      int unsigned n;
      int unsigned first;
      int          i;
      first = expected_bytes.size();
      if (it.action == ACT_FLUSH) begin
        if (held_count > 0) begin
          acc = {1'b0, held_bits} << (BYTE_BITS - held_count);
          b.out_byte = acc;
          b.last_byte = 1'b0;
          expected_bytes.push_back(b);
          held_bits = '0;
          held_count = 0;
        end
      end else begin
        n = 32'(it.bit_count);
        if (n > FIELD_LIMIT)
          n = FIELD_LIMIT;
        acc = {1'b0, held_bits};
        for (i = n; i > 0; i--) begin
          acc = {acc[6:0], it.value_bits[i-1]};
          held_count++;
          if (held_count == BYTE_BITS) begin
            b.out_byte = acc;
            b.last_byte = 1'b0;
            expected_bytes.push_back(b);
            acc = '0;
            held_count = 0;
          end
        end
        held_bits = acc[6:0];
      end
      // mark the final byte of this item
      if (expected_bytes.size() > first) begin
        b = expected_bytes.pop_back();
        b.last_byte = 1'b1;
        expected_bytes.push_back(b);
      end
    endfunction

    function void check_byte(out_t got);
      out_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte %02h last %0b", $time, got.out_byte, got.last_byte);
      end else begin
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
          errors++;
          $display("%0t: out_byte expected %02h actual %02h",
                   $time, want.out_byte, got.out_byte);
        end
        if (got.last_byte !== want.last_byte) begin
          errors++;
          $display("%0t: last_byte expected %0b actual %0b",
                   $time, want.last_byte, got.last_byte);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic push;
  logic full;
  in_t  item;
  logic empty;
  logic pop;
  out_t result;
  bit   quiet;

  packed_byte_tracker tracker = new();

  msb_first_bit_packer_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [VALUE_W-1:0] rand_value();
    return VALUE_W'({$urandom, $urandom});
  endfunction

  function automatic in_t make_write(int unsigned count, logic [VALUE_W-1:0] value);
    in_t it;
    it.action = ACT_APPEND;
    it.bit_count = COUNT_W'(count);
    it.value_bits = value;
    return it;
  endfunction

  function automatic in_t make_flush();
    in_t it;
    it.action = ACT_FLUSH;
    it.bit_count = COUNT_W'($urandom);
    it.value_bits = rand_value();
    return it;
  endfunction

  // Drive one beat; called at a falling edge, returns at a falling edge once the beat is taken.
  task automatic send_item(in_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    push = 1'b1;
    item = it;
    do
      @(posedge clk);
    while (full);
    tracker.note_item(it);
    @(negedge clk);
  endtask

  task automatic drain();
    push = 1'b0;
    while (tracker.expected_bytes.size() != 0)
      @(negedge clk);
  endtask

  function automatic in_t random_item();
    in_t it;
    int unsigned count;
    if ($urandom_range(0, 4) == 0)
      return make_flush();
    case ($urandom_range(0, 3))
      0: count = $urandom_range(0, 63);
      1: count = $urandom_range(1, 9);
      2: count = $urandom_range(50, 63);
      default: begin
        case ($urandom_range(0, 4))
          0: count = 0;
          1: count = 1;
          2: count = 7;
          3: count = 8;
          default: count = 63;
        endcase
      end
    endcase
    it = make_write(count, rand_value());
    return it;
  endfunction

  // result side: sample at the rising edge, change pop at the falling edge
  initial begin
    int unsigned stall;
    pop = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty)
        tracker.check_byte(result);
      @(negedge clk);
      if (rst) begin
        pop = 1'b0;
      end else if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        pop = 1'b0;
        stall = $urandom_range(1, 9) - 1;
      end else begin
        pop = 1'b1;
      end
    end
  end

  initial begin
    int n;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    quiet = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    send_item(make_flush());
    send_item(make_write(0, '1));
    send_item(make_write(63, '1));
    send_item(make_write(1, 63'd1));
    send_item(make_write(63, '0));
    send_item(make_write(63, VALUE_W'({32{2'b01}})));
    send_item(make_write(4, {{59{1'b1}}, 4'b1010}));
    send_item(make_flush());
    send_item(make_flush());
    send_item(make_write(7, 63'h7f));
    send_item(make_write(63, rand_value()));
    send_item(make_write(8, {{55{1'b1}}, 8'ha5}));
    send_item(make_flush());
    send_item(make_write(3, 63'd5));
    send_item('{action: ACT_FLUSH, bit_count: '1, value_bits: '1});
    send_item(make_write(63, VALUE_W'({32{2'b10}})));
    send_item(make_write(1, 63'd0));
    send_item(make_flush());
    send_item(make_write(62, rand_value()));
    send_item(make_write(0, rand_value()));
    send_item(make_flush());

    // random part
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2)
        drain();
      quiet = (n >= RANDOM_ITEMS - 30);
      send_item(random_item());
    end
    send_item(make_flush());

    drain();
    repeat (20) @(negedge clk);
    if (tracker.errors == 0 && tracker.expected_bytes.size() == 0)
      $display("msb_first_bit_packer_top verification clean");
    else
      $display("msb_first_bit_packer_top verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("msb_first_bit_packer_top verification failed");
    $finish;
  end

endmodule
